// ===== rtl/core/qacpm_pkg.sv =====
package qacpm_pkg;

    // register map, word index into the APB window
    localparam logic [2:0] REG_TRIM_PITCH = 3'd0;
    localparam logic [2:0] REG_TRIM_ROLL  = 3'd1;
    localparam logic [2:0] REG_OUTER_KP   = 3'd2;
    localparam logic [2:0] REG_OUTER_KI   = 3'd3;
    localparam logic [2:0] REG_INNER_KP   = 3'd4;
    localparam logic [2:0] REG_INNER_KI   = 3'd5;
    localparam logic [2:0] REG_INNER_KD   = 3'd6;
    localparam logic [2:0] REG_YAW_KP     = 3'd7;

    localparam logic [17:0] OUTER_KP_RST = 18'd143360;
    localparam logic [17:0] OUTER_KI_RST = 18'd41;
    localparam logic [17:0] INNER_KP_RST = 18'd1229;
    localparam logic [17:0] INNER_KI_RST = 18'd41;
    localparam logic [17:0] INNER_KD_RST = 18'd36864;
    localparam logic [17:0] YAW_KP_RST   = 18'd20480;

    localparam int A_W   = 26;
    localparam int B_W   = 30;
    localparam int ACC_W = 58;

    // reciprocals with 32 fraction bits, rounded up
    localparam logic [B_W-1:0] RECIP_131 = 30'd32786010;
    localparam logic [B_W-1:0] RECIP_7   = 30'd613566757;
    localparam logic [B_W-1:0] YAW_KI    = 30'd819;
    localparam logic [B_W-1:0] YAW_KD    = 30'd16384;

    localparam logic signed [17:0] INT_LIM  = 18'sd128000;
    localparam logic signed [10:0] AXIS_LIM = 11'sd1000;

    typedef struct packed {
        logic signed [16:0] trim_pitch;
        logic signed [16:0] trim_roll;
        logic [17:0]        outer_kp;
        logic [17:0]        outer_ki;
        logic [17:0]        inner_kp;
        logic [17:0]        inner_ki;
        logic [17:0]        inner_kd;
        logic [17:0]        yaw_kp;
    } cfg_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clr;
    } mac_ctl_t;

    function automatic logic signed [17:0] sat_int(input logic signed [27:0] v);
        if (v > 28'(INT_LIM))
            return INT_LIM;
        else if (v < -28'(INT_LIM))
            return -INT_LIM;
        else
            return v[17:0];
    endfunction

    function automatic logic signed [10:0] sat_axis(input logic signed [25:0] v);
        if (v > 26'(AXIS_LIM))
            return AXIS_LIM;
        else if (v < -26'(AXIS_LIM))
            return -AXIS_LIM;
        else
            return v[10:0];
    endfunction

    function automatic logic [9:0] clamp_pwm(input logic signed [21:0] v);
        if (v > 22'sd1000)
            return 10'd1000;
        else if (v < 22'sd0)
            return 10'd0;
        else
            return v[9:0];
    endfunction

endpackage

// ===== rtl/core/qacpm_regs.sv =====
module qacpm_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output qacpm_pkg::cfg_t      cfg
);
    qacpm_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0] idx;

    assign idx = paddr[4:2];
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (idx)
                qacpm_pkg::REG_TRIM_PITCH: cfg_next.trim_pitch = pwdata[16:0];
                qacpm_pkg::REG_TRIM_ROLL:  cfg_next.trim_roll  = pwdata[16:0];
                qacpm_pkg::REG_OUTER_KP:   cfg_next.outer_kp   = pwdata[17:0];
                qacpm_pkg::REG_OUTER_KI:   cfg_next.outer_ki   = pwdata[17:0];
                qacpm_pkg::REG_INNER_KP:   cfg_next.inner_kp   = pwdata[17:0];
                qacpm_pkg::REG_INNER_KI:   cfg_next.inner_ki   = pwdata[17:0];
                qacpm_pkg::REG_INNER_KD:   cfg_next.inner_kd   = pwdata[17:0];
                qacpm_pkg::REG_YAW_KP:     cfg_next.yaw_kp     = pwdata[17:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            qacpm_pkg::REG_TRIM_PITCH: prdata = {15'd0, cfg_reg.trim_pitch};
            qacpm_pkg::REG_TRIM_ROLL:  prdata = {15'd0, cfg_reg.trim_roll};
            qacpm_pkg::REG_OUTER_KP:   prdata = {14'd0, cfg_reg.outer_kp};
            qacpm_pkg::REG_OUTER_KI:   prdata = {14'd0, cfg_reg.outer_ki};
            qacpm_pkg::REG_INNER_KP:   prdata = {14'd0, cfg_reg.inner_kp};
            qacpm_pkg::REG_INNER_KI:   prdata = {14'd0, cfg_reg.inner_ki};
            qacpm_pkg::REG_INNER_KD:   prdata = {14'd0, cfg_reg.inner_kd};
            qacpm_pkg::REG_YAW_KP:     prdata = {14'd0, cfg_reg.yaw_kp};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trim_pitch <= '0;
            cfg_reg.trim_roll  <= '0;
            cfg_reg.outer_kp   <= qacpm_pkg::OUTER_KP_RST;
            cfg_reg.outer_ki   <= qacpm_pkg::OUTER_KI_RST;
            cfg_reg.inner_kp   <= qacpm_pkg::INNER_KP_RST;
            cfg_reg.inner_ki   <= qacpm_pkg::INNER_KI_RST;
            cfg_reg.inner_kd   <= qacpm_pkg::INNER_KD_RST;
            cfg_reg.yaw_kp     <= qacpm_pkg::YAW_KP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

// ===== rtl/core/qacpm_mac.sv =====
module qacpm_mac (
    input  logic                                   aclk,
    input  qacpm_pkg::mac_ctl_t                    ctl,
    input  logic signed [qacpm_pkg::A_W-1:0]       op_a,
    input  logic [qacpm_pkg::B_W-1:0]              op_b,
    output logic signed [qacpm_pkg::ACC_W-1:0]     acc
);
    logic signed [qacpm_pkg::A_W+qacpm_pkg::B_W:0] prod_reg, prod_next;
    logic signed [qacpm_pkg::ACC_W-1:0]            acc_reg, acc_next;

    // product registered before it reaches the adder
    assign prod_next = op_a * $signed({1'b0, op_b});

    always_comb begin
        acc_next = acc_reg;
        if (ctl.acc_en)
            acc_next = (ctl.clr ? '0 : acc_reg) + qacpm_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;
endmodule

// ===== rtl/core/qacpm_seq.sv =====
module qacpm_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qacpm_pkg::cfg_t                     cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [127:0]                        s_tdata,
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata,
    output logic [0:0]                          m_tuser,
    output qacpm_pkg::mac_ctl_t                 mac_ctl,
    output logic signed [qacpm_pkg::A_W-1:0]    op_a,
    output logic [qacpm_pkg::B_W-1:0]           op_b,
    input  logic signed [qacpm_pkg::ACC_W-1:0]  acc
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic [1:0] PH_MUL  = 2'd0;
    localparam logic [1:0] PH_ACC  = 2'd1;
    localparam logic [1:0] PH_POST = 2'd2;

    localparam logic [4:0] ST_RATE_X  = 5'd0;
    localparam logic [4:0] ST_RATE_Y  = 5'd1;
    localparam logic [4:0] ST_RATE_Z  = 5'd2;
    localparam logic [4:0] ST_ANG_1   = 5'd3;
    localparam logic [4:0] ST_ANG_2   = 5'd4;
    localparam logic [4:0] ST_OX_P    = 5'd5;
    localparam logic [4:0] ST_OX_I    = 5'd6;
    localparam logic [4:0] ST_IX_P    = 5'd7;
    localparam logic [4:0] ST_IX_I    = 5'd8;
    localparam logic [4:0] ST_IX_D    = 5'd9;
    localparam logic [4:0] ST_OY_P    = 5'd10;
    localparam logic [4:0] ST_OY_I    = 5'd11;
    localparam logic [4:0] ST_IY_P    = 5'd12;
    localparam logic [4:0] ST_IY_I    = 5'd13;
    localparam logic [4:0] ST_IY_D    = 5'd14;
    localparam logic [4:0] ST_YAW_P   = 5'd15;
    localparam logic [4:0] ST_YAW_I   = 5'd16;
    localparam logic [4:0] ST_YAW_D   = 5'd17;

    logic [1:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] phase_reg, phase_next;

    logic [7:0] seq_reg, b1_reg, b2_reg, b3_reg, b4_reg, prev_seq_reg;
    logic [6:0] loss_reg;
    logic [7:0] thr_reg;
    logic       lost_reg;

    logic signed [15:0] gx_reg, gy_reg, gz_reg;
    logic signed [16:0] pitch_reg, roll_reg;
    logic signed [17:0] rx_reg, ry_reg, rz_reg;
    logic signed [13:0] ang1_reg, ang2_reg;
    logic signed [25:0] o_reg;
    logic signed [10:0] px_reg, py_reg;
    logic signed [19:0] z_reg;
    logic signed [17:0] oint_x_reg, oint_y_reg, iint_x_reg, iint_y_reg, yint_reg;
    logic signed [17:0] prior_rx_reg, prior_ry_reg;
    logic signed [19:0] prior_e_reg;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        out_lost_reg;

    logic accept, arm, post, out_free;
    logic signed [18:0] ax, ay;
    logic signed [19:0] e;
    logic signed [8:0]  d1, d2, d3;

    // accept-cycle packet / link handling
    logic [7:0] nb0, nb1, nb2, nb3, nb4;
    logic [7:0] cnt;
    logic       lost_now;
    logic [6:0] loss_new;

    // rate and angle magnitudes for the reciprocal divides
    logic [15:0] mag_x, mag_y, mag_z;
    logic [7:0]  mag1, mag2;

    logic [17:0] q_rate;
    logic [12:0] q_ang;
    logic signed [qacpm_pkg::ACC_W-1:0] rnd12, rnd20;

    logic signed [21:0] m0, m1, m2, m3;
    logic [9:0]         thr4;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign arm      = thr_reg > 8'd20;
    assign post     = (state_reg == S_RUN) && (phase_reg == PH_POST);
    assign out_free = !out_valid_reg || m_tready;

    assign d1 = $signed({1'b0, b1_reg}) - 9'sd128;
    assign d2 = $signed({1'b0, b2_reg}) - 9'sd128;
    assign d3 = $signed({1'b0, b3_reg}) - 9'sd128;

    assign ax = 19'(pitch_reg) - 19'(ang1_reg) - 19'(cfg.trim_pitch);
    assign ay = 19'(roll_reg) + 19'(ang2_reg) - 19'(cfg.trim_roll);
    assign e  = 20'(rz_reg) - 20'($signed({d3, 8'd0}));

    assign mag_x = gx_reg[15] ? 16'(-17'(gx_reg)) : gx_reg;
    assign mag_y = gy_reg[15] ? 16'(-17'(gy_reg)) : gy_reg;
    assign mag_z = gz_reg[15] ? 16'(-17'(gz_reg)) : gz_reg;
    assign mag1  = d1[8] ? 8'(-d1) : d1[7:0];
    assign mag2  = d2[8] ? 8'(-d2) : d2[7:0];

    assign q_rate = {1'b0, acc[48:32]};
    assign q_ang  = acc[44:32];
    assign rnd12  = acc + qacpm_pkg::ACC_W'(2048);
    assign rnd20  = acc + qacpm_pkg::ACC_W'(524288);

    // packet store and failsafe
    always_comb begin
        nb0 = s_tuser[0] ? s_tdata[7:0]   : seq_reg;
        nb1 = s_tuser[0] ? s_tdata[15:8]  : b1_reg;
        nb2 = s_tuser[0] ? s_tdata[23:16] : b2_reg;
        nb3 = s_tuser[0] ? s_tdata[31:24] : b3_reg;
        nb4 = s_tuser[0] ? s_tdata[39:32] : b4_reg;
        cnt      = {1'b0, loss_reg} + 8'd1;
        lost_now = 1'b0;
        loss_new = 7'd0;
        if (nb0 == prev_seq_reg) begin
            loss_new = cnt[6:0];
            if (cnt[7]) begin
                lost_now = 1'b1;
                loss_new = 7'd120;
            end
        end
    end

    // operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        mac_ctl.clr = 1'b0;
        case (step_reg)
            ST_RATE_X: begin
                op_a = qacpm_pkg::A_W'({mag_x, 9'd0} + 25'd65);
                op_b = qacpm_pkg::RECIP_131; mac_ctl.clr = 1'b1;
            end
            ST_RATE_Y: begin
                op_a = qacpm_pkg::A_W'({mag_y, 9'd0} + 25'd65);
                op_b = qacpm_pkg::RECIP_131; mac_ctl.clr = 1'b1;
            end
            ST_RATE_Z: begin
                op_a = qacpm_pkg::A_W'({mag_z, 9'd0} + 25'd65);
                op_b = qacpm_pkg::RECIP_131; mac_ctl.clr = 1'b1;
            end
            ST_ANG_1: begin
                op_a = qacpm_pkg::A_W'({mag1, 8'd0} + 16'd3);
                op_b = qacpm_pkg::RECIP_7; mac_ctl.clr = 1'b1;
            end
            ST_ANG_2: begin
                op_a = qacpm_pkg::A_W'({mag2, 8'd0} + 16'd3);
                op_b = qacpm_pkg::RECIP_7; mac_ctl.clr = 1'b1;
            end
            ST_OX_P: begin
                op_a = qacpm_pkg::A_W'(ax);
                op_b = qacpm_pkg::B_W'(cfg.outer_kp); mac_ctl.clr = 1'b1;
            end
            ST_OX_I: begin
                op_a = qacpm_pkg::A_W'(oint_x_reg);
                op_b = qacpm_pkg::B_W'(cfg.outer_ki);
            end
            ST_IX_P: begin
                op_a = qacpm_pkg::A_W'(ry_reg) + qacpm_pkg::A_W'(o_reg);
                op_b = qacpm_pkg::B_W'(cfg.inner_kp); mac_ctl.clr = 1'b1;
            end
            ST_IX_I: begin
                op_a = qacpm_pkg::A_W'(iint_x_reg);
                op_b = qacpm_pkg::B_W'(cfg.inner_ki);
            end
            ST_IX_D: begin
                op_a = qacpm_pkg::A_W'(ry_reg) - qacpm_pkg::A_W'(prior_ry_reg);
                op_b = qacpm_pkg::B_W'(cfg.inner_kd);
            end
            ST_OY_P: begin
                op_a = qacpm_pkg::A_W'(ay);
                op_b = qacpm_pkg::B_W'(cfg.outer_kp); mac_ctl.clr = 1'b1;
            end
            ST_OY_I: begin
                op_a = qacpm_pkg::A_W'(oint_y_reg);
                op_b = qacpm_pkg::B_W'(cfg.outer_ki);
            end
            ST_IY_P: begin
                op_a = qacpm_pkg::A_W'(rx_reg) + qacpm_pkg::A_W'(o_reg);
                op_b = qacpm_pkg::B_W'(cfg.inner_kp); mac_ctl.clr = 1'b1;
            end
            ST_IY_I: begin
                op_a = qacpm_pkg::A_W'(iint_y_reg);
                op_b = qacpm_pkg::B_W'(cfg.inner_ki);
            end
            ST_IY_D: begin
                op_a = qacpm_pkg::A_W'(rx_reg) - qacpm_pkg::A_W'(prior_rx_reg);
                op_b = qacpm_pkg::B_W'(cfg.inner_kd);
            end
            ST_YAW_P: begin
                op_a = qacpm_pkg::A_W'(e);
                op_b = qacpm_pkg::B_W'(cfg.yaw_kp); mac_ctl.clr = 1'b1;
            end
            ST_YAW_I: begin
                op_a = qacpm_pkg::A_W'(yint_reg);
                op_b = qacpm_pkg::YAW_KI;
            end
            ST_YAW_D: begin
                op_a = qacpm_pkg::A_W'(e) - qacpm_pkg::A_W'(prior_e_reg);
                op_b = qacpm_pkg::YAW_KD;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        mac_ctl.mul_en = (state_reg == S_RUN) && (phase_reg == PH_MUL);
        mac_ctl.acc_en = (state_reg == S_RUN) && (phase_reg == PH_ACC);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RUN;
                    step_next  = ST_RATE_X;
                    phase_next = PH_MUL;
                end
            end
            S_RUN: begin
                if (phase_reg == PH_POST) begin
                    phase_next = PH_MUL;
                    step_next  = step_reg + 5'd1;
                    if (step_reg == ST_YAW_D)
                        state_next = S_DONE;
                end else begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            S_DONE: begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // motor mix
    assign thr4 = {thr_reg, 2'b00};
    assign m0 = 22'(thr4) - 22'(px_reg) + 22'(z_reg);
    assign m1 = 22'(thr4) - 22'(py_reg) - 22'(z_reg);
    assign m2 = 22'(thr4) + 22'(px_reg) + 22'(z_reg);
    assign m3 = 22'(thr4) + 22'(py_reg) - 22'(z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_RATE_X;
            phase_reg     <= PH_MUL;
            seq_reg       <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            b3_reg        <= '0;
            b4_reg        <= '0;
            prev_seq_reg  <= '0;
            loss_reg      <= '0;
            oint_x_reg    <= '0;
            oint_y_reg    <= '0;
            iint_x_reg    <= '0;
            iint_y_reg    <= '0;
            yint_reg      <= '0;
            prior_rx_reg  <= '0;
            prior_ry_reg  <= '0;
            prior_e_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;

            if (accept) begin
                seq_reg      <= nb0;
                b1_reg       <= lost_now ? 8'd128 : nb1;
                b2_reg       <= lost_now ? 8'd128 : nb2;
                b3_reg       <= lost_now ? 8'd128 : nb3;
                b4_reg       <= (lost_now && nb4 != 8'd0) ? nb4 - 8'd1 : nb4;
                prev_seq_reg <= nb0;
                loss_reg     <= loss_new;
            end

            if (post) begin
                if (step_reg == ST_OX_P) begin
                    oint_x_reg <= arm ? qacpm_pkg::sat_int(28'(oint_x_reg) + 28'(ax)) : '0;
                    oint_y_reg <= arm ? qacpm_pkg::sat_int(28'(oint_y_reg) + 28'(ay)) : '0;
                    yint_reg   <= arm ? qacpm_pkg::sat_int(28'(yint_reg) + 28'(e)) : '0;
                end
                if (step_reg == ST_IX_P)
                    iint_x_reg <= arm ? qacpm_pkg::sat_int(28'(iint_x_reg) + 28'(ry_reg)
                                                          - 28'(o_reg)) : '0;
                if (step_reg == ST_IY_P)
                    iint_y_reg <= arm ? qacpm_pkg::sat_int(28'(iint_y_reg) + 28'(rx_reg)
                                                          - 28'(o_reg)) : '0;
            end

            if (state_reg == S_DONE && out_free) begin
                prior_rx_reg <= rx_reg;
                prior_ry_reg <= ry_reg;
                prior_e_reg  <= e;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            thr_reg   <= nb4;
            lost_reg  <= lost_now;
            gx_reg    <= s_tdata[55:40];
            gy_reg    <= s_tdata[71:56];
            gz_reg    <= s_tdata[87:72];
            pitch_reg <= s_tdata[104:88];
            roll_reg  <= s_tdata[121:105];
        end
        if (post) begin
            case (step_reg)
                ST_RATE_X: rx_reg <= gx_reg[15] ? -q_rate : q_rate;
                ST_RATE_Y: ry_reg <= gy_reg[15] ? -q_rate : q_rate;
                ST_RATE_Z: rz_reg <= gz_reg[15] ? -q_rate : q_rate;
                ST_ANG_1:  ang1_reg <= d1[8] ? -14'(q_ang) : 14'(q_ang);
                ST_ANG_2:  ang2_reg <= d2[8] ? -14'(q_ang) : 14'(q_ang);
                ST_OX_I, ST_OY_I: o_reg <= rnd12[37:12];
                ST_IX_D:   px_reg <= qacpm_pkg::sat_axis(rnd20[45:20]);
                ST_IY_D:   py_reg <= qacpm_pkg::sat_axis(rnd20[45:20]);
                ST_YAW_D:  z_reg  <= rnd20[39:20];
                default: ;
            endcase
        end
        if (state_reg == S_DONE && out_free) begin
            out_lost_reg <= lost_reg;
            if (thr_reg < 8'd10)
                out_data_reg <= '0;
            else
                out_data_reg <= {qacpm_pkg::clamp_pwm(m3), qacpm_pkg::clamp_pwm(m2),
                                 qacpm_pkg::clamp_pwm(m1), qacpm_pkg::clamp_pwm(m0)};
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_lost_reg;
endmodule

// ===== rtl/core/quad_attitude_cascade_pid_mixer_top.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  one control tick request (sensors + radio)
// m_        out        m_tvalid / m_tready  four motor PWM values + failsafe flag
// apb       in         psel/penable/pwrite  trims and loop gains, 8 words
//
// One request runs 18 multiply steps (multiply, accumulate, post phases) on the single
// shared multiply-accumulate unit, plus accept and result hand-over.
// Reset (aresetn low, synchronous) clears state, integrators and loads the default gains.
// A finished result sits in the output register; the next request is taken
// meanwhile and only waits at its last cycle if that result is still unread.
module quad_attitude_cascade_pid_mixer_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] packet_seq, [15:8] roll_stick, [23:16] pitch_stick, [31:24] yaw_stick,
    // [39:32] throttle_stick, [55:40] gyro_raw_x, [71:56] gyro_raw_y,
    // [87:72] gyro_raw_z, [104:88] pitch_estimate, [121:105] roll_estimate, rest zero
    input  logic [127:0] s_tdata,
    // [0] new_packet
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [9:0] motor_front_right, [19:10] motor_rear_left,
    // [29:20] motor_front_left, [39:30] motor_rear_right
    output logic [39:0]  m_tdata,
    // [0] link_lost
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    qacpm_pkg::cfg_t                          cfg;
    qacpm_pkg::mac_ctl_t                      mac_ctl;
    logic signed [qacpm_pkg::A_W-1:0]         op_a;
    logic [qacpm_pkg::B_W-1:0]                op_b;
    logic signed [qacpm_pkg::ACC_W-1:0]       acc;

    assign pready = 1'b1;

    // configuration registers
    qacpm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // shared multiply-accumulate
    qacpm_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // sequencer, loop state and output register
    qacpm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .mac_ctl  (mac_ctl),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc      (acc)
    );
endmodule
